// File: rtl/core/assert_macros.svh
// assertion macros for the rtl modules, included by the top-level core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/vccs_pkg.sv
// shared types and constants for the verlet circle constraint core
package vccs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SQ_W          = 66;
  localparam int ROOT_W        = SQ_W / 2;
  localparam int NUM_W         = 64;
  localparam int QUO_W         = 32;

  typedef enum logic [2:0] {
    CFG_GRAVITY_X,
    CFG_GRAVITY_Y,
    CFG_STEP_DT,
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_BOUNDARY_RADIUS
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] prev_x;
    logic [31:0] prev_y;
    logic        clamp;
    logic        neg_x;
    logic        neg_y;
    logic [62:0] prod_x;
    logic [62:0] prod_y;
  } side_t;

endpackage

// File: rtl/core/vccs_sqrt.sv
// pipelined floor square root, one root bit per stage, sideband carried along
module vccs_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [vccs_pkg::SQ_W-1:0]     in_sq,
  input  vccs_pkg::side_t               in_side,
  output logic                          out_valid,
  output logic [vccs_pkg::ROOT_W-1:0]   out_root,
  output vccs_pkg::side_t               out_side
);
  import vccs_pkg::*;

  localparam int STAGES = ROOT_W;

  logic              valid_r [STAGES];
  logic [ROOT_W+2:0] rem_r   [STAGES];
  logic [ROOT_W-1:0] root_r  [STAGES];
  logic [SQ_W-1:0]   sq_r    [STAGES];
  side_t             side_r  [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic              v_prev;
    logic [ROOT_W+2:0] rem_prev;
    logic [ROOT_W-1:0] root_prev;
    logic [SQ_W-1:0]   sq_prev;
    side_t             side_prev;
    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign v_prev    = in_valid;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign sq_prev   = in_sq;
      assign side_prev = in_side;
    end else begin : g_rest
      assign v_prev    = valid_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign root_prev = root_r[k-1];
      assign sq_prev   = sq_r[k-1];
      assign side_prev = side_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_prev[ROOT_W:0], sq_prev[SQ_W-1 -: 2]};
      trial  = {1'b0, root_prev, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_prev[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_prev[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        sq_r[k]   <= sq_prev << 2;
        side_r[k] <= side_prev;
      end
    end
  end

  assign out_valid = valid_r[STAGES-1];
  assign out_root  = root_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

endmodule

// File: rtl/core/vccs_div.sv
// pipelined two-lane restoring divider, one quotient bit per stage
module vccs_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [1:0][vccs_pkg::NUM_W-1:0]      in_num,
  input  logic [vccs_pkg::ROOT_W-1:0]          in_den,
  input  vccs_pkg::side_t                      in_side,
  output logic                                 out_valid,
  output logic [1:0][vccs_pkg::QUO_W-1:0]      out_quo,
  output vccs_pkg::side_t                      out_side
);
  import vccs_pkg::*;

  localparam int STAGES = QUO_W;
  localparam int DEN_W  = ROOT_W;

  logic                       valid_r [STAGES];
  logic [1:0][DEN_W:0]        rem_r   [STAGES];
  logic [1:0][QUO_W-1:0]      lo_r    [STAGES];
  logic [1:0][QUO_W-1:0]      quo_r   [STAGES];
  logic [DEN_W-1:0]           den_r   [STAGES];
  side_t                      side_r  [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic                  v_prev;
    logic [1:0][DEN_W:0]   rem_prev;
    logic [1:0][QUO_W-1:0] lo_prev;
    logic [1:0][QUO_W-1:0] quo_prev;
    logic [DEN_W-1:0]      den_prev;
    side_t                 side_prev;
    logic [1:0][DEN_W:0]   rem_nxt;
    logic [1:0][QUO_W-1:0] quo_nxt;
    logic [1:0][QUO_W-1:0] lo_nxt;

    if (k == 0) begin : g_first
      assign v_prev      = in_valid;
      assign rem_prev[0] = {{(DEN_W+1-QUO_W){1'b0}}, in_num[0][NUM_W-1 -: QUO_W]};
      assign rem_prev[1] = {{(DEN_W+1-QUO_W){1'b0}}, in_num[1][NUM_W-1 -: QUO_W]};
      assign lo_prev[0]  = in_num[0][QUO_W-1:0];
      assign lo_prev[1]  = in_num[1][QUO_W-1:0];
      assign quo_prev    = '0;
      assign den_prev    = in_den;
      assign side_prev   = in_side;
    end else begin : g_rest
      assign v_prev    = valid_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign lo_prev   = lo_r[k-1];
      assign quo_prev  = quo_r[k-1];
      assign den_prev  = den_r[k-1];
      assign side_prev = side_r[k-1];
    end

    always_comb begin
      logic [DEN_W:0] rem_sh;
      for (int l = 0; l < 2; l++) begin
        rem_sh    = {rem_prev[l][DEN_W-1:0], lo_prev[l][QUO_W-1]};
        lo_nxt[l] = lo_prev[l] << 1;
        if (rem_sh >= {1'b0, den_prev}) begin
          rem_nxt[l] = rem_sh - {1'b0, den_prev};
          quo_nxt[l] = {quo_prev[l][QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[l] = rem_sh;
          quo_nxt[l] = {quo_prev[l][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        lo_r[k]   <= lo_nxt;
        quo_r[k]  <= quo_nxt;
        den_r[k]  <= den_prev;
        side_r[k] <= side_prev;
      end
    end
  end

  assign out_valid = valid_r[STAGES-1];
  assign out_quo   = quo_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

endmodule

// File: rtl/core/verlet_circle_constraint_step_core.sv
// top level: one verlet sub-step with circular boundary projection per particle
// Takes one particle per cycle and returns one result per particle, in order, through
// the input register, difference, multiply (with the clamp compare behind it), 33-stage
// square root, numerator add, 32-stage divider, projection and verlet update stages. The two
// bit-per-stage pipelines, square root and divider, make up most of the depth; throughput is one
// transaction per cycle while out_tready is high. The whole pipeline holds when a
// result waits at the output. Configuration writes take effect for transactions that
// are accepted in the same cycle as the write or later; write only while the pipeline
// is empty.
`include "assert_macros.svh"

module verlet_circle_constraint_step_core #(
  parameter int FRAC_BITS = vccs_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, prev_x, prev_y, object_radius, one zero pad bit
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // next_x, next_y, last_x, last_y
  output logic [127:0] out_tdata,
  // was_clamped, saturated
  output logic [1:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import vccs_pkg::*;

  function automatic logic [32:0] sat32(input logic [34:0] v);
    logic [32:0] res;
    if (!v[34] && (v[33:31] != 3'b000)) begin
      res = {1'b1, 32'h7fff_ffff};
    end else if (v[34] && (v[33:31] != 3'b111)) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  // configuration registers
  logic [31:0] grav_x_r, grav_y_r, step_dt_r, center_x_r, center_y_r;
  logic [30:0] bnd_radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_x_r     <= '0;
      grav_y_r     <= 32'(1000 << FRAC_BITS);
      step_dt_r    <= 32'd35791394;
      center_x_r   <= '0;
      center_y_r   <= '0;
      bnd_radius_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAVITY_X:       grav_x_r     <= cfg_wdata;
        CFG_GRAVITY_Y:       grav_y_r     <= cfg_wdata;
        CFG_STEP_DT:         step_dt_r    <= cfg_wdata;
        CFG_CENTER_X:        center_x_r   <= cfg_wdata;
        CFG_CENTER_Y:        center_y_r   <= cfg_wdata;
        CFG_BOUNDARY_RADIUS: bnd_radius_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // gravity times dt squared, derived from the static registers
  logic [63:0] dt_sq_r, gpx_r, gpy_r;
  logic [31:0] dt2_r, gmx, gmy, accx_mag, accy_mag;
  logic [32:0] acc_x_r, acc_y_r;

  assign gmx      = grav_x_r[31] ? 32'(-grav_x_r) : grav_x_r;
  assign gmy      = grav_y_r[31] ? 32'(-grav_y_r) : grav_y_r;
  assign accx_mag = 32'((65'(gpx_r) + 65'h8000_0000) >> 32);
  assign accy_mag = 32'((65'(gpy_r) + 65'h8000_0000) >> 32);

  always_ff @(posedge clk) begin
    dt_sq_r <= 64'(step_dt_r) * 64'(step_dt_r);
    dt2_r   <= 32'((65'(dt_sq_r) + 65'h8000_0000) >> 32);
    gpx_r   <= 64'(gmx) * 64'(dt2_r);
    gpy_r   <= 64'(gmy) * 64'(dt2_r);
    acc_x_r <= grav_x_r[31] ? 33'(-{1'b0, accx_mag}) : {1'b0, accx_mag};
    acc_y_r <= grav_y_r[31] ? 33'(-{1'b0, accy_mag}) : {1'b0, accy_mag};
  end

  logic en;
  logic out_tvalid_r;
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // stage a: input register
  logic        a_valid_r;
  logic [31:0] a_pos_x_r, a_pos_y_r, a_prev_x_r, a_prev_y_r;
  logic [30:0] a_orad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_valid_r <= 1'b0;
    else if (en) a_valid_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pos_x_r  <= in_tdata[31:0];
      a_pos_y_r  <= in_tdata[63:32];
      a_prev_x_r <= in_tdata[95:64];
      a_prev_y_r <= in_tdata[127:96];
      a_orad_r   <= in_tdata[158:128];
    end
  end

  // stage b: offsets from center, inner radius
  logic [32:0] vx, vy;
  logic [31:0] rr;
  assign vx = {center_x_r[31], center_x_r} - {a_pos_x_r[31], a_pos_x_r};
  assign vy = {center_y_r[31], center_y_r} - {a_pos_y_r[31], a_pos_y_r};
  assign rr = {1'b0, bnd_radius_r} - {1'b0, a_orad_r};

  logic        b_valid_r, b_rneg_r, b_negx_r, b_negy_r;
  logic [31:0] b_ax_r, b_ay_r, b_pos_x_r, b_pos_y_r, b_prev_x_r, b_prev_y_r;
  logic [30:0] b_rm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_valid_r <= 1'b0;
    else if (en) b_valid_r <= a_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ax_r     <= vx[32] ? 32'(-vx) : vx[31:0];
      b_ay_r     <= vy[32] ? 32'(-vy) : vy[31:0];
      b_rm_r     <= rr[31] ? 31'(-rr) : rr[30:0];
      b_rneg_r   <= rr[31];
      b_negx_r   <= vx[32] != rr[31];
      b_negy_r   <= vy[32] != rr[31];
      b_pos_x_r  <= a_pos_x_r;
      b_pos_y_r  <= a_pos_y_r;
      b_prev_x_r <= a_prev_x_r;
      b_prev_y_r <= a_prev_y_r;
    end
  end

  // stage c: squares and scaled offsets
  logic        c_valid_r, c_rneg_r, c_negx_r, c_negy_r;
  logic [63:0] c_sqx_r, c_sqy_r;
  logic [61:0] c_r2_r;
  logic [62:0] c_prodx_r, c_prody_r;
  logic [31:0] c_pos_x_r, c_pos_y_r, c_prev_x_r, c_prev_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_valid_r <= 1'b0;
    else if (en) c_valid_r <= b_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sqx_r    <= 64'(b_ax_r) * 64'(b_ax_r);
      c_sqy_r    <= 64'(b_ay_r) * 64'(b_ay_r);
      c_r2_r     <= 62'(b_rm_r) * 62'(b_rm_r);
      c_prodx_r  <= 63'(b_ax_r) * 63'(b_rm_r);
      c_prody_r  <= 63'(b_ay_r) * 63'(b_rm_r);
      c_rneg_r   <= b_rneg_r;
      c_negx_r   <= b_negx_r;
      c_negy_r   <= b_negy_r;
      c_pos_x_r  <= b_pos_x_r;
      c_pos_y_r  <= b_pos_y_r;
      c_prev_x_r <= b_prev_x_r;
      c_prev_y_r <= b_prev_y_r;
    end
  end

  // distance squared and clamp decision, into the square root
  logic [64:0] s_sum;
  logic        clamp;
  side_t       c_side;

  assign s_sum = {1'b0, c_sqx_r} + {1'b0, c_sqy_r};
  assign clamp = (s_sum != '0) && (c_rneg_r || (s_sum > {3'b000, c_r2_r}));

  always_comb begin
    c_side.pos_x  = c_pos_x_r;
    c_side.pos_y  = c_pos_y_r;
    c_side.prev_x = c_prev_x_r;
    c_side.prev_y = c_prev_y_r;
    c_side.clamp  = clamp;
    c_side.neg_x  = c_negx_r;
    c_side.neg_y  = c_negy_r;
    c_side.prod_x = c_prodx_r;
    c_side.prod_y = c_prody_r;
  end

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;

  vccs_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_valid_r),
    .in_sq     ({1'b0, s_sum}),
    .in_side   (c_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // stage e: rounding numerators
  logic                  e_valid_r;
  logic [1:0][NUM_W-1:0] e_num_r;
  logic [ROOT_W-1:0]     e_den_r;
  side_t                 e_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_valid_r <= 1'b0;
    else if (en) e_valid_r <= sq_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_num_r[0] <= {1'b0, sq_side.prod_x} + NUM_W'(sq_root >> 1);
      e_num_r[1] <= {1'b0, sq_side.prod_y} + NUM_W'(sq_root >> 1);
      e_den_r    <= sq_root;
      e_side_r   <= sq_side;
    end
  end

  logic                  dv_valid;
  logic [1:0][QUO_W-1:0] dv_quo;
  side_t                 dv_side;

  vccs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (e_valid_r),
    .in_num    (e_num_r),
    .in_den    (e_den_r),
    .in_side   (e_side_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // stage f: projected position
  logic [33:0] cx34, cy34, lx34, ly34;
  logic [32:0] lx_sat, ly_sat;

  assign cx34 = {{2{center_x_r[31]}}, center_x_r};
  assign cy34 = {{2{center_y_r[31]}}, center_y_r};

  always_comb begin
    if (!dv_side.clamp) begin
      lx34 = {{2{dv_side.pos_x[31]}}, dv_side.pos_x};
      ly34 = {{2{dv_side.pos_y[31]}}, dv_side.pos_y};
    end else begin
      lx34 = dv_side.neg_x ? cx34 + {2'b00, dv_quo[0]} : cx34 - {2'b00, dv_quo[0]};
      ly34 = dv_side.neg_y ? cy34 + {2'b00, dv_quo[1]} : cy34 - {2'b00, dv_quo[1]};
    end
    lx_sat = sat32({lx34[33], lx34});
    ly_sat = sat32({ly34[33], ly34});
  end

  logic        f_valid_r, f_clamp_r, f_lsat_r;
  logic [31:0] f_last_x_r, f_last_y_r, f_prev_x_r, f_prev_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) f_valid_r <= 1'b0;
    else if (en) f_valid_r <= dv_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_last_x_r <= lx_sat[31:0];
      f_last_y_r <= ly_sat[31:0];
      f_lsat_r   <= lx_sat[32] | ly_sat[32];
      f_clamp_r  <= dv_side.clamp;
      f_prev_x_r <= dv_side.prev_x;
      f_prev_y_r <= dv_side.prev_y;
    end
  end

  // stage g: verlet update into the output register
  logic [34:0] nx35, ny35;
  logic [32:0] nx_sat, ny_sat;

  assign nx35 = {{2{f_last_x_r[31]}}, f_last_x_r, 1'b0} - {{3{f_prev_x_r[31]}}, f_prev_x_r}
              + {{2{acc_x_r[32]}}, acc_x_r};
  assign ny35 = {{2{f_last_y_r[31]}}, f_last_y_r, 1'b0} - {{3{f_prev_y_r[31]}}, f_prev_y_r}
              + {{2{acc_y_r[32]}}, acc_y_r};
  assign nx_sat = sat32(nx35);
  assign ny_sat = sat32(ny35);

  logic [127:0] out_tdata_r;
  logic [1:0]   out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (en) out_tvalid_r <= f_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {f_last_y_r, f_last_x_r, ny_sat[31:0], nx_sat[31:0]};
      out_tuser_r <= {f_lsat_r | nx_sat[32] | ny_sat[32], f_clamp_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `ASSERT_IMPLIES(a_stall_needs_held_result, !in_tready, out_tvalid && !out_tready,
                  "pipeline stalled without a waiting result")
  `ASSERT_IMPLIES(a_zero_dist_not_clamped, c_valid_r && (s_sum == '0), !clamp,
                  "particle at the center was clamped")
  `ASSERT_IMPLIES(a_unclamped_last_exact, f_valid_r && !f_clamp_r, !f_lsat_r,
                  "unclamped position saturated")

endmodule
